// ===== rtl/pcpa_pkg.sv =====
package pcpa_pkg;

  localparam int NUM_CPUS_DEF  = 8;
  localparam int NUM_PAGES_DEF = 4096;

  localparam int CPU_W    = 3;
  localparam int PAGE_W   = 12;
  localparam int REG_W    = 13;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 1;

  localparam logic CMD_FREE  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [IDX_W-1:0] REG_FIRST_PAGE = 1'b0;
  localparam logic [IDX_W-1:0] REG_LIMIT_PAGE = 1'b1;

  localparam logic [REG_W-1:0] FIRST_PAGE_RST = 13'd0;
  localparam logic [REG_W-1:0] LIMIT_PAGE_RST = 13'd4096;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PAGE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic free_go;      // push the incoming page (range checked)
    logic pop_start;    // own list non-empty: latch top, read its link
    logic steal_start;  // own list empty: latch victim, start length walk
    logic fail;         // nothing to take anywhere
    logic count_step;   // one more node on the victim list
    logic seek_start;   // start walk to the cut point
    logic seek_step;    // advance towards the cut point
    logic cut_none;     // single-node victim: move it whole
    logic cut;          // terminate stolen part, victim keeps the rest
    logic pop_read;     // read link of the new top
    logic pop_done;     // pop and deliver the item's result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic own_valid;
    logic any_victim;
    logic rd_end;
    logic cnt_cap;
    logic steps_zero;
    logic rem_zero;
  } dp_sts_t;

endpackage

// ===== rtl/pcpa_ctrl.sv =====
module pcpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              cmd,
  input  pcpa_pkg::dp_sts_t sts,
  output logic              busy,
  output pcpa_pkg::dp_cmd_t ctl
);
  import pcpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_COUNT  = 5'b00010,
    S_SEEK   = 5'b00100,
    S_POP_RD = 5'b01000,
    S_POP    = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd == CMD_FREE) begin
            ctl.free_go = 1'b1;
          end else if (sts.own_valid) begin
            ctl.pop_start = 1'b1;
            state_next    = S_POP;
          end else if (sts.any_victim) begin
            ctl.steal_start = 1'b1;
            state_next      = S_COUNT;
          end else begin
            ctl.fail = 1'b1;
          end
        end
      end
      S_COUNT: begin
        if (sts.rd_end || sts.cnt_cap) begin
          if (sts.steps_zero) begin
            ctl.cut_none = 1'b1;
            state_next   = S_POP_RD;
          end else begin
            ctl.seek_start = 1'b1;
            state_next     = S_SEEK;
          end
        end else begin
          ctl.count_step = 1'b1;
        end
      end
      S_SEEK: begin
        if (sts.rem_zero) begin
          ctl.cut    = 1'b1;
          state_next = S_POP_RD;
        end else begin
          ctl.seek_step = 1'b1;
        end
      end
      S_POP_RD: begin
        ctl.pop_read = 1'b1;
        state_next   = S_POP;
      end
      S_POP: begin
        ctl.pop_done = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/pcpa_dp.sv =====
module pcpa_dp #(
  parameter int NUM_CPUS  = pcpa_pkg::NUM_CPUS_DEF,
  parameter int NUM_PAGES = pcpa_pkg::NUM_PAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pcpa_pkg::IDX_W-1:0]      cfg_index,
  input  logic [pcpa_pkg::REG_W-1:0]      cfg_data,
  input  logic [pcpa_pkg::CPU_W-1:0]      cpu,
  input  logic [pcpa_pkg::PAGE_W-1:0]     page,
  input  pcpa_pkg::dp_cmd_t               ctl,
  output pcpa_pkg::dp_sts_t               sts,
  output logic                            done,
  output logic [pcpa_pkg::PAGE_W-1:0]     granted_page,
  output logic [pcpa_pkg::STATUS_W-1:0]   status
);
  import pcpa_pkg::*;

  localparam int CW   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int PW   = $clog2(NUM_PAGES);
  localparam int LW   = PW + 1;   // end flag on top of the page index
  localparam int CNTW = $clog2(2 * NUM_PAGES + 1);
  localparam logic [CNTW-1:0] CNT_CAP     = CNTW'(2 * NUM_PAGES);
  localparam logic [16:0]     NUM_PAGES_W = 17'(NUM_PAGES);
  localparam logic [LW-1:0]   LINK_END    = {1'b1, {PW{1'b0}}};

  function automatic logic [CW-1:0] cpu_mod(input logic [CPU_W-1:0] c);
    logic [4:0] v;
    v = 5'(c);
    for (int i = 0; i < 8; i++) begin
      if (v >= 5'(NUM_CPUS)) v = v - 5'(NUM_CPUS);
    end
    return v[CW-1:0];
  endfunction

  logic [LW-1:0]     head [NUM_CPUS];
  logic [LW-1:0]     mem  [NUM_PAGES];
  logic [LW-1:0]     rd_data;
  logic [PW-1:0]     rd_addr;
  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic [LW-1:0]     wr_data;

  logic [CW-1:0]     r_cpu;
  logic [CW-1:0]     r_vic;
  logic [PW-1:0]     top;
  logic [PW-1:0]     p;
  logic [CNTW-1:0]   cnt;
  logic [REG_W-1:0]  first_page;
  logic [REG_W-1:0]  limit_page;

  logic [CW-1:0]     cpu_in;
  logic [CW-1:0]     vic_idx;
  logic              vic_found;
  logic              in_range;
  logic [PW+11:0]    page_wide;
  logic [PW-1:0]     page_idx;
  logic [PW+11:0]    top_wide;

  assign cpu_in    = cpu_mod(cpu);
  assign page_wide = {{PW{1'b0}}, page};
  assign page_idx  = page_wide[PW-1:0];
  assign top_wide  = {{PAGE_W{1'b0}}, top};
  assign in_range  = ({1'b0, page} >= first_page) && ({1'b0, page} < limit_page) &&
                     (17'(page) < NUM_PAGES_W);

  // lowest-numbered other CPU with a non-empty list
  always_comb begin
    vic_found = 1'b0;
    vic_idx   = '0;
    for (int v = 0; v < NUM_CPUS; v++) begin
      if (!vic_found && (CW'(v) != cpu_in) && !head[v][PW]) begin
        vic_found = 1'b1;
        vic_idx   = CW'(v);
      end
    end
  end

  always_comb begin
    if (ctl.pop_start) begin
      rd_addr = head[cpu_in][PW-1:0];
    end else if (ctl.steal_start) begin
      rd_addr = head[vic_idx][PW-1:0];
    end else if (ctl.count_step || ctl.seek_step) begin
      rd_addr = rd_data[PW-1:0];
    end else begin
      rd_addr = top;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p;
    wr_data = LINK_END;
    if (ctl.free_go && in_range) begin
      wr_en   = 1'b1;
      wr_addr = page_idx;
      wr_data = head[cpu_in];
    end else if (ctl.cut) begin
      wr_en = 1'b1;
    end
  end

  // link memory: one write port, one read port, registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CPUS; i++) head[i] <= LINK_END;
    end else begin
      if (ctl.free_go && in_range) begin
        head[cpu_in] <= {1'b0, page_idx};
      end
      if (ctl.cut_none) begin
        head[r_vic] <= LINK_END;
        head[r_cpu] <= {1'b0, top};
      end
      if (ctl.cut) begin
        head[r_vic] <= rd_data;
        head[r_cpu] <= {1'b0, top};
      end
      if (ctl.pop_done) begin
        head[r_cpu] <= rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop_start) begin
      r_cpu <= cpu_in;
      top   <= head[cpu_in][PW-1:0];
    end
    if (ctl.steal_start) begin
      r_cpu <= cpu_in;
      r_vic <= vic_idx;
      top   <= head[vic_idx][PW-1:0];
      cnt   <= CNTW'(1);
    end
    if (ctl.count_step) begin
      cnt <= cnt + CNTW'(1);
    end
    if (ctl.seek_start) begin
      p   <= top;
      cnt <= (cnt >> 1) - CNTW'(1);
    end
    if (ctl.seek_step) begin
      p   <= rd_data[PW-1:0];
      cnt <= cnt - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= FIRST_PAGE_RST;
      limit_page <= LIMIT_PAGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_PAGE: first_page <= cfg_data;
        REG_LIMIT_PAGE: limit_page <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.free_go | ctl.fail | ctl.pop_done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.free_go) begin
      granted_page <= '0;
      status       <= in_range ? ST_OK : ST_BAD_PAGE;
    end else if (ctl.fail) begin
      granted_page <= '0;
      status       <= ST_EMPTY;
    end else if (ctl.pop_done) begin
      granted_page <= top_wide[PAGE_W-1:0];
      status       <= ST_OK;
    end
  end

  assign sts.own_valid  = !head[cpu_in][PW];
  assign sts.any_victim = vic_found;
  assign sts.rd_end     = rd_data[PW];
  assign sts.cnt_cap    = (cnt == CNT_CAP);
  assign sts.steps_zero = (cnt[CNTW-1:1] == '0);
  assign sts.rem_zero   = (cnt == '0);

endmodule

// ===== rtl/per_cpu_page_free_list_allocator_top.sv =====
// Free: result strobed in the cycle after accept, busy stays low (1 item per cycle).
// Alloc from own list: result strobed in the same cycle that busy falls.
// Alloc with nothing anywhere: status empty.
// Alloc with steal: the victim list is walked node by node through the single read port of
// the link memory to count its length L (capped at 2*NUM_PAGES), then again to the cut point.
// Synchronous reset empties every list and restores the page range; receiver cannot stall.
module per_cpu_page_free_list_allocator_top #(
  parameter int NUM_CPUS  = pcpa_pkg::NUM_CPUS_DEF,
  parameter int NUM_PAGES = pcpa_pkg::NUM_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [pcpa_pkg::CPU_W-1:0]    cpu,
  input  logic [pcpa_pkg::PAGE_W-1:0]   page,
  input  logic                          cfg_we,
  input  logic [pcpa_pkg::IDX_W-1:0]    cfg_index,
  input  logic [pcpa_pkg::REG_W-1:0]    cfg_data,
  output logic                          done,
  output logic [pcpa_pkg::PAGE_W-1:0]   granted_page,
  output logic [pcpa_pkg::STATUS_W-1:0] status
);
  import pcpa_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  pcpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  pcpa_dp #(
    .NUM_CPUS  (NUM_CPUS),
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cpu          (cpu),
    .page         (page),
    .ctl          (ctl),
    .sts          (sts),
    .done         (done),
    .granted_page (granted_page),
    .status       (status)
  );

endmodule

// ===== test/per_cpu_page_free_list_allocator_top_test.sv =====
module per_cpu_page_free_list_allocator_top_test;
  import pcpa_pkg::*;

  localparam int NCPU        = NUM_CPUS_DEF;
  localparam int NPG         = NUM_PAGES_DEF;
  localparam int STALL_LIMIT = 40000;
  localparam int PHASE_ITEMS = 120;

  typedef struct packed {
    logic              empty;
    logic [PAGE_W-1:0] pg;
  } link_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   granted;
    logic [STATUS_W-1:0] status;
  } grant_t;

  localparam link_t LINK_NONE = '{empty: 1'b1, pg: '0};

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  logic                busy;
  logic                cmd       = CMD_FREE;
  logic [CPU_W-1:0]    cpu       = '0;
  logic [PAGE_W-1:0]   page      = '0;
  logic                cfg_we    = 1'b0;
  logic [IDX_W-1:0]    cfg_index = REG_FIRST_PAGE;
  logic [REG_W-1:0]    cfg_data  = '0;
  logic                done;
  logic [PAGE_W-1:0]   granted_page;
  logic [STATUS_W-1:0] status;

  // free list state as the block should hold it
  link_t            free_head [NCPU] = '{default: LINK_NONE};
  link_t            page_link [NPG]  = '{default: '0};
  logic [REG_W-1:0] first_reg = FIRST_PAGE_RST;
  logic [REG_W-1:0] limit_reg = LIMIT_PAGE_RST;

  // pages currently outside every list, so a free of one is well formed
  bit held_pg [NPG] = '{default: 1'b1};

  grant_t grant_q [$];

  int err_cnt   = 0;
  int n_frees   = 0;
  int n_allocs  = 0;
  int n_results = 0;
  int n_steals  = 0;
  int n_bad     = 0;
  int n_empty   = 0;
  int n_cfg     = 0;
  int stall_cnt = 0;

  per_cpu_page_free_list_allocator_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .cpu          (cpu),
    .page         (page),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .granted_page (granted_page),
    .status       (status)
  );

  always #6 clk = ~clk;

  // move the front half of the victim list over to the thief
  function automatic bit steal_half(int victim, int thief);
    link_t head, fast, slow, prev;
    int    steps;
    head = free_head[victim];
    if (head.empty) return 1'b0;
    fast  = head;
    slow  = head;
    prev  = head;
    steps = 0;
    // bounded so that looped lists still terminate
    while (!fast.empty && !page_link[fast.pg].empty && steps < NPG) begin
      fast  = page_link[page_link[fast.pg].pg];
      prev  = slow;
      slow  = page_link[slow.pg];
      steps++;
    end
    free_head[thief] = head;
    if (steps == 0) begin
      free_head[victim] = LINK_NONE;
    end else begin
      free_head[victim] = slow;
      page_link[prev.pg] = LINK_NONE;
    end
    return 1'b1;
  endfunction

  function automatic grant_t predict_grant(logic c, logic [CPU_W-1:0] cp,
                                           logic [PAGE_W-1:0] pg);
    grant_t r;
    int     self;
    bit     have;
    link_t  top;
    r    = '{granted: '0, status: ST_OK};
    self = int'(cp) % NCPU;
    if (c == CMD_FREE) begin
      if (pg < first_reg || pg >= limit_reg || int'(pg) >= NPG) begin
        r.status = ST_BAD_PAGE;
      end else begin
        page_link[pg]   = free_head[self];
        free_head[self] = '{empty: 1'b0, pg: pg};
      end
    end else begin
      have = !free_head[self].empty;
      for (int v = 0; v < NCPU && !have; v++) begin
        if (v != self) begin
          have = steal_half(v, self);
          if (have) n_steals++;
        end
      end
      if (have) begin
        top             = free_head[self];
        free_head[self] = page_link[top.pg];
        r.granted       = top.pg;
      end else begin
        r.status = ST_EMPTY;
      end
    end
    return r;
  endfunction

  // a held page inside the current range, searched from a random point
  function automatic bit pick_free_page(output logic [PAGE_W-1:0] pg);
    int lo, hi, span, base, cand;
    lo = int'(first_reg);
    hi = (int'(limit_reg) > NPG) ? NPG : int'(limit_reg);
    pg = '0;
    if (lo >= hi) return 1'b0;
    span = hi - lo;
    base = $urandom_range(span - 1);
    for (int n = 0; n < span; n++) begin
      cand = lo + (base + n) % span;
      if (held_pg[cand]) begin
        pg = PAGE_W'(cand);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic note_error(string msg);
    if (err_cnt < 10) $display("ERROR at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic send_item(logic c, logic [CPU_W-1:0] cp, logic [PAGE_W-1:0] pg);
    grant_t want;
    @(negedge clk);
    start = 1'b1;
    cmd   = c;
    cpu   = cp;
    page  = pg;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_grant(c, cp, pg);
    grant_q.push_back(want);
    if (c == CMD_FREE) n_frees++;
    else n_allocs++;
    if (want.status == ST_BAD_PAGE) n_bad++;
    if (want.status == ST_EMPTY) n_empty++;
    if (c == CMD_FREE && want.status == ST_OK) held_pg[pg] = 1'b0;
    if (c == CMD_ALLOC && want.status == ST_OK) held_pg[want.granted] = 1'b1;
  endtask

  task automatic pause(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = REG_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_FIRST_PAGE) first_reg = REG_W'(val);
    else limit_reg = REG_W'(val);
  endtask

  task automatic set_range(int first, int limit);
    settle();
    write_reg(REG_FIRST_PAGE, first);
    write_reg(REG_LIMIT_PAGE, limit);
    n_cfg++;
  endtask

  task automatic test_empty_and_own_pop();
    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_FREE, 7, 0);
    send_item(CMD_FREE, 7, 4095);
    send_item(CMD_ALLOC, 7, 0);
    send_item(CMD_ALLOC, 7, 4095);
  endtask

  // victim lengths 5, 3, 2 and 1 in turn
  task automatic test_steal();
    for (int p = 1; p <= 5; p++) send_item(CMD_FREE, 6, PAGE_W'(p));
    send_item(CMD_ALLOC, 2, 0);
    send_item(CMD_ALLOC, 2, 0);
    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_ALLOC, 4, 0);
    send_item(CMD_ALLOC, 1, 0);
  endtask

  task automatic test_page_range();
    set_range(100, 200);
    send_item(CMD_FREE, 0, 99);
    send_item(CMD_FREE, 0, 100);
    send_item(CMD_FREE, 0, 199);
    send_item(CMD_FREE, 0, 200);
    set_range(300, 200);
    send_item(CMD_FREE, 1, 250);
    set_range(4096, 4096);
    send_item(CMD_FREE, 2, 4095);
    set_range(0, 0);
    send_item(CMD_FREE, 3, 0);
    set_range(0, 4096);
    send_item(CMD_ALLOC, 5, 0);
    send_item(CMD_ALLOC, 0, 0);
  endtask

  task automatic test_random_mix();
    int               lo, hi, ap, r, burst_left;
    bit               gapless, found;
    logic [PAGE_W-1:0] pg;
    logic [CPU_W-1:0]  cp;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin lo = 0;    hi = 4096; ap = 45; end
        1: begin lo = 1;    hi = 4095; ap = 35; end
        2: begin lo = 2048; hi = 2560; ap = 40; end
        3: begin lo = 0;    hi = 1;    ap = 50; end
        4: begin lo = 4095; hi = 4096; ap = 50; end
        5: begin lo = 4096; hi = 0;    ap = 50; end
        6: begin lo = 3000; hi = 1000; ap = 45; end
        7: begin lo = 0;    hi = 4096; ap = 30; end
        8: begin lo = 0;    hi = 4096; ap = 60; end
        default: begin lo = 0; hi = 0; ap = 50; end
      endcase
      set_range(lo, hi);
      gapless    = ($urandom_range(2) == 0);
      burst_left = 0;
      repeat (PHASE_ITEMS) begin
        if (burst_left == 0) begin
          if (!gapless) pause($urandom_range(1, 6));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        r  = $urandom_range(99);
        cp = CPU_W'($urandom_range(NCPU - 1));
        if (r < ap) begin
          send_item(CMD_ALLOC, cp, PAGE_W'($urandom_range(NPG - 1)));
        end else begin
          found = 1'b0;
          if (r < 92) found = pick_free_page(pg);
          // noise: a random page, unless that would free a listed page twice
          if (!found) begin
            pg    = PAGE_W'($urandom_range(NPG - 1));
            found = (pg < first_reg || pg >= limit_reg) || held_pg[pg];
          end
          if (found) send_item(CMD_FREE, cp, pg);
          else send_item(CMD_ALLOC, cp, pg);
        end
      end
    end
  endtask

  // lists emptied first so that the looped list is the first victim
  task automatic test_repeated_free();
    bit listed;
    settle();
    forever begin
      listed = 1'b0;
      for (int v = 0; v < NCPU; v++) if (!free_head[v].empty) listed = 1'b1;
      if (!listed) break;
      send_item(CMD_ALLOC, 0, 0);
    end
    send_item(CMD_FREE, 3, 10);
    send_item(CMD_FREE, 3, 10);
    send_item(CMD_FREE, 3, 20);
    send_item(CMD_ALLOC, 5, 0);
    send_item(CMD_ALLOC, 5, 0);
    send_item(CMD_ALLOC, 3, 0);
    send_item(CMD_FREE, 6, 30);
    send_item(CMD_FREE, 7, 30);
    send_item(CMD_ALLOC, 6, 0);
    send_item(CMD_ALLOC, 7, 0);
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst && done) begin
      n_results++;
      if (grant_q.size() == 0) begin
        note_error($sformatf("result with nothing expected: page %0d status %0d",
                             granted_page, status));
      end else begin
        want = grant_q.pop_front();
        if (granted_page !== want.granted || status !== want.status)
          note_error($sformatf("granted_page %0d status %0d, expected %0d status %0d",
                               granted_page, status, want.granted, want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no item accepted for %0d cycles", stall_cnt);
      $display("per_cpu_page_free_list_allocator_top test failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_empty_and_own_pop();
    test_steal();
    test_page_range();
    test_random_mix();
    test_repeated_free();
    settle();
    repeat (20) @(posedge clk);
    if (grant_q.size() != 0)
      note_error($sformatf("%0d results never arrived", grant_q.size()));
    $display("covered %0d frees and %0d allocates, %0d results, %0d steals",
             n_frees, n_allocs, n_results, n_steals);
    $display("%0d bad-page and %0d empty results over %0d page ranges, %0d errors",
             n_bad, n_empty, n_cfg, err_cnt);
    if (err_cnt == 0) begin
      $display("per_cpu_page_free_list_allocator_top test passed");
    end else begin
      $display("per_cpu_page_free_list_allocator_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pcpa_pkg.sv
rtl/pcpa_ctrl.sv
rtl/pcpa_dp.sv
rtl/per_cpu_page_free_list_allocator_top.sv
test/per_cpu_page_free_list_allocator_top_test.sv
